// File: hw/rtl/sst_pkg.sv
// Shared types, constants and helpers for the strongest signal table.
package sst_pkg;
    localparam int ENTRIES    = 16;
    localparam int NAME_BYTES = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        REQ_CLEAR  = 3'd0,
        REQ_BEGIN  = 3'd1,
        REQ_ADD    = 3'd2,
        REQ_FINISH = 3'd3,
        REQ_LOOKUP = 3'd4,
        REQ_READ   = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_NOT_AVAIL = 3'd1,
        ST_STALE    = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FOUND    = 3'd4,
        ST_RANGE    = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_MIN, S_SORT_PICK, S_SORT_SHIFT, S_SORT_DROP, S_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic          latch;      // capture the request
        logic          empty;      // empty the table
        logic          zero_stamp;
        logic          set_ready;  // stamp time and mark scan ready
        logic          scan_clr;   // reset the walk index
        logic          scan_step;
        logic          add_hit;    // update the matched entry
        logic          add_new;    // append at held_count
        logic          add_repl;   // replace the weakest entry
        logic          sort_pick;  // take slot i as the key
        logic          sort_shift; // move j-1 up to j
        logic          sort_drop;  // write key at j, advance i
        logic          resp_load;
    } t_cmd;

    typedef struct packed {
        t_req       req;
        logic       name_empty;
        logic       match;      // entry at walk index matches
        logic       scan_end;   // walk index reached held_count
        logic       min_end;
        logic       table_full;
        logic       stronger;   // new level beats the weakest
        logic       sort_done;  // i reached held_count
        logic       shift_go;   // key beats entry j-1 and j>0
        logic       ready;
        logic       stale;
    } t_stat;

    function automatic logic [255:0] norm_name(input logic [255:0] nm);
        logic [255:0] r;
        logic         ended;
        r = '0;
        ended = 1'b0;
        for (int b = 0; b < 32; b++) begin
            if (b >= NAME_BYTES || nm[b*8 +: 8] == 8'd0) ended = 1'b1;
            if (!ended) r[b*8 +: 8] = nm[b*8 +: 8];
        end
        return r;
    endfunction
endpackage

// File: hw/rtl/sst_ctrl.sv
// Controller state machine of the strongest signal table.
module sst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  sst_pkg::t_stat i_stat,
    output sst_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_strobe
);
    import sst_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // The request is latched on the accepting edge, so decode uses the
    // registered copy from S_SCAN onward.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_go) n_state = S_SCAN;
            S_SCAN: begin
                case (i_stat.req)
                    REQ_ADD: begin
                        if (i_stat.name_empty) n_state = S_RESP;
                        else if (i_stat.match) n_state = S_RESP;
                        else if (i_stat.scan_end)
                            n_state = i_stat.table_full ? S_MIN : S_RESP;
                    end
                    REQ_LOOKUP: begin
                        if (i_stat.name_empty || !i_stat.ready || i_stat.stale)
                            n_state = S_RESP;
                        else if (i_stat.match || i_stat.scan_end) n_state = S_RESP;
                    end
                    REQ_FINISH: n_state = S_SORT_PICK;
                    default:    n_state = S_RESP;
                endcase
            end
            S_MIN:        if (i_stat.min_end) n_state = S_RESP;
            S_SORT_PICK:  n_state = i_stat.sort_done ? S_RESP : S_SORT_SHIFT;
            S_SORT_SHIFT: if (!i_stat.shift_go) n_state = S_SORT_DROP;
            S_SORT_DROP:  n_state = S_SORT_PICK;
            S_RESP:       n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != S_IDLE);
        o_strobe = (r_state == S_RESP);
        case (r_state)
            S_IDLE: begin
                o_cmd.latch    = i_go;
                o_cmd.scan_clr = i_go;
            end
            S_SCAN: begin
                case (i_stat.req)
                    REQ_CLEAR: begin
                        o_cmd.empty = 1'b1;
                        o_cmd.zero_stamp = 1'b1;
                    end
                    REQ_BEGIN: o_cmd.empty = 1'b1;
                    REQ_ADD: begin
                        if (!i_stat.name_empty) begin
                            if (i_stat.match) o_cmd.add_hit = 1'b1;
                            else if (i_stat.scan_end) begin
                                if (!i_stat.table_full) o_cmd.add_new = 1'b1;
                                else o_cmd.scan_clr = 1'b1;
                            end else o_cmd.scan_step = 1'b1;
                        end
                    end
                    REQ_LOOKUP: begin
                        if (!(i_stat.name_empty || !i_stat.ready || i_stat.stale)
                            && !i_stat.match && !i_stat.scan_end)
                            o_cmd.scan_step = 1'b1;
                    end
                    REQ_FINISH: begin
                        o_cmd.set_ready = 1'b1;
                        o_cmd.scan_clr  = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_MIN: begin
                if (i_stat.min_end) o_cmd.add_repl = i_stat.stronger;
                else o_cmd.scan_step = 1'b1;
            end
            S_SORT_PICK:  o_cmd.sort_pick = !i_stat.sort_done;
            S_SORT_SHIFT: o_cmd.sort_shift = i_stat.shift_go;
            S_SORT_DROP:  o_cmd.sort_drop = 1'b1;
            S_RESP:       o_cmd.resp_load = 1'b0;
            default: ;
        endcase
        if (n_state == S_RESP && r_state != S_RESP) o_cmd.resp_load = 1'b1;
    end

    as_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("strobe held for two cycles");
    as_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_busy) else $error("strobe while idle");
    as_go_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && !o_busy) |=> (r_state == S_SCAN)) else $error("request lost");
endmodule

// File: hw/rtl/sst_dp.sv
// Datapath of the strongest signal table: storage, walk index, sort and result.
module sst_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sst_pkg::t_cmd             i_cmd,
    input  logic [2:0]                i_req_type,
    input  logic [255:0]              i_name,
    input  logic signed [7:0]         i_signal_level,
    input  logic [7:0]                i_radio_channel,
    input  logic [31:0]               i_time_ms,
    input  logic [7:0]                i_entry_index,
    input  logic [31:0]               i_max_age_ms,
    output sst_pkg::t_stat            o_stat,
    output logic [2:0]                o_status,
    output logic [255:0]              o_name,
    output logic signed [7:0]         o_level,
    output logic [7:0]                o_channel,
    output logic [4:0]                o_total,
    output logic                      o_ready,
    output logic [31:0]               o_stamp
);
    import sst_pkg::*;

    logic [255:0]      r_names [ENTRIES];
    logic signed [7:0] r_lvls  [ENTRIES];
    logic [7:0]        r_chs   [ENTRIES];
    logic [CNT_W-1:0]  r_cnt;
    logic [31:0]       r_stamp;
    logic              r_ready;

    logic [2:0]        r_req;
    logic [255:0]      r_nm;
    logic signed [7:0] r_lvl;
    logic [7:0]        r_ch;
    logic [31:0]       r_now;
    logic [7:0]        r_ix;

    logic [CNT_W-1:0]  r_i;      // walk index, or sort outer index
    logic [CNT_W-1:0]  r_j;      // sort inner index
    logic [IDX_W-1:0]  r_min;
    logic [255:0]      r_knm;
    logic signed [7:0] r_klv;
    logic [7:0]        r_kch;

    logic [IDX_W-1:0]  w_iix, w_jix, w_jm1;
    logic [31:0]       w_age;
    logic              w_inrange;

    assign w_iix = r_i[IDX_W-1:0];
    assign w_jix = r_j[IDX_W-1:0];
    assign w_jm1 = w_jix - IDX_W'(1);
    assign w_age = r_now - r_stamp;
    assign w_inrange = ({1'b0, r_ix} < 9'(r_cnt));

    always_comb begin
        o_stat = '0;
        o_stat.req        = t_req'(r_req);
        o_stat.name_empty = (r_nm[7:0] == 8'd0);
        o_stat.scan_end   = (r_i >= r_cnt);
        o_stat.match      = !o_stat.scan_end && (r_names[w_iix] == r_nm);
        o_stat.table_full = (r_cnt == CNT_W'(ENTRIES));
        o_stat.min_end    = (r_i >= CNT_W'(ENTRIES));
        o_stat.stronger   = (r_lvl > r_lvls[r_min]);
        o_stat.sort_done  = (r_i >= r_cnt);
        o_stat.shift_go   = (r_j != '0) && (r_klv > r_lvls[w_jm1]);
        o_stat.ready      = r_ready;
        o_stat.stale      = (i_max_age_ms != 32'd0) && (w_age > i_max_age_ms);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req_type;
            r_nm  <= norm_name(i_name);
            r_lvl <= i_signal_level;
            r_ch  <= i_radio_channel;
            r_now <= i_time_ms;
            r_ix  <= i_entry_index;
        end
        if (i_cmd.scan_clr) begin
            r_i   <= '0;
            r_min <= '0;
        end else if (i_cmd.scan_step) begin
            r_i <= r_i + CNT_W'(1);
            if (r_i < CNT_W'(ENTRIES) && r_lvls[w_iix] < r_lvls[r_min]) r_min <= w_iix;
        end else if (i_cmd.set_ready) begin
            r_i <= CNT_W'(1);
        end else if (i_cmd.sort_drop) begin
            r_i <= r_i + CNT_W'(1);
        end
        if (i_cmd.sort_pick) begin
            r_knm <= r_names[w_iix];
            r_klv <= r_lvls[w_iix];
            r_kch <= r_chs[w_iix];
            r_j   <= r_i;
        end else if (i_cmd.sort_shift) begin
            r_j <= r_j - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.empty) begin
            for (int k = 0; k < ENTRIES; k++) begin
                r_names[k] <= '0;
                r_lvls[k]  <= '0;
                r_chs[k]   <= '0;
            end
        end else begin
            if (i_cmd.add_hit && r_lvl > r_lvls[w_iix]) begin
                r_lvls[w_iix] <= r_lvl;
                r_chs[w_iix]  <= r_ch;
            end
            if (i_cmd.add_new) begin
                r_names[w_iix] <= r_nm;
                r_lvls[w_iix]  <= r_lvl;
                r_chs[w_iix]   <= r_ch;
            end
            if (i_cmd.add_repl) begin
                r_names[r_min] <= r_nm;
                r_lvls[r_min]  <= r_lvl;
                r_chs[r_min]   <= r_ch;
            end
            if (i_cmd.sort_shift) begin
                r_names[w_jix] <= r_names[w_jm1];
                r_lvls[w_jix]  <= r_lvls[w_jm1];
                r_chs[w_jix]   <= r_chs[w_jm1];
            end
            if (i_cmd.sort_drop) begin
                r_names[w_jix] <= r_knm;
                r_lvls[w_jix]  <= r_klv;
                r_chs[w_jix]   <= r_kch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_stamp <= '0;
            r_ready <= 1'b0;
        end else begin
            if (i_cmd.empty) begin
                r_cnt   <= '0;
                r_ready <= 1'b0;
            end else if (i_cmd.add_new) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.zero_stamp) r_stamp <= '0;
            if (i_cmd.set_ready) begin
                r_stamp <= r_now;
                r_ready <= 1'b1;
            end
        end
    end

    // Result register; loaded on the last working cycle and shown in S_RESP.
    always_ff @(posedge i_clk) begin
        if (i_cmd.resp_load) begin
            o_status  <= ST_DONE;
            o_name    <= '0;
            o_level   <= '0;
            o_channel <= '0;
            case (t_req'(r_req))
                REQ_LOOKUP: begin
                    if (o_stat.name_empty || !r_ready) o_status <= ST_NOT_AVAIL;
                    else if (o_stat.stale) o_status <= ST_STALE;
                    else if (o_stat.match) begin
                        o_status  <= ST_FOUND;
                        o_name    <= r_names[w_iix];
                        o_level   <= r_lvls[w_iix];
                        o_channel <= r_chs[w_iix];
                    end else o_status <= ST_NOT_FOUND;
                end
                REQ_READ: begin
                    if (w_inrange) begin
                        o_status  <= ST_FOUND;
                        o_name    <= r_names[r_ix[IDX_W-1:0]];
                        o_level   <= r_lvls[r_ix[IDX_W-1:0]];
                        o_channel <= r_chs[r_ix[IDX_W-1:0]];
                    end else o_status <= ST_RANGE;
                end
                default: ;
            endcase
        end
    end

    assign o_total = 5'(r_cnt);
    assign o_ready = r_ready;
    assign o_stamp = r_stamp;

    as_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(ENTRIES)) else $error("held count beyond table size");
    as_add_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_new |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("append did not grow the table");
    as_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.empty |=> (r_cnt == '0 && !r_ready)) else $error("table not emptied");
endmodule

// File: hw/rtl/strongest_signal_table_core.sv
// Top level of the strongest signal table.
//  channel  | direction | handshake                 | payload
//  request  | in        | i_start high, o_busy low  | request fields
//  result   | out       | o_strobe, one cycle       | result fields
//  config   | in        | i_cfg_valid & o_cfg_ready | max_age_ms
// An add or lookup walks up to 16 entries of the table, a full-table add then
// walks the whole table again to find the weakest, and finish runs an insertion
// sort at one move per cycle (worst case with sixteen entries held in ascending
// order of level).
// Reset is synchronous; the table comes up empty with no clearing pass.
// The result is shown for one cycle and cannot be held off.
module strongest_signal_table_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_req_type,
    input  logic [63:0]        i_name_word0,
    input  logic [63:0]        i_name_word1,
    input  logic [63:0]        i_name_word2,
    input  logic [63:0]        i_name_word3,
    input  logic signed [7:0]  i_signal_level,
    input  logic [7:0]         i_radio_channel,
    input  logic [31:0]        i_time_ms,
    input  logic [7:0]         i_entry_index,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    output logic               o_strobe,
    output logic [2:0]         o_status,
    output logic [63:0]        o_out_word0,
    output logic [63:0]        o_out_word1,
    output logic [63:0]        o_out_word2,
    output logic [63:0]        o_out_word3,
    output logic signed [7:0]  o_out_level,
    output logic [7:0]         o_out_channel,
    output logic [4:0]         o_entry_total,
    output logic               o_scan_ready,
    output logic [31:0]        o_scan_stamp
);
    import sst_pkg::*;

    t_cmd         w_cmd;
    t_stat        w_stat;
    logic [31:0]  r_max_age;
    logic [255:0] w_name;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_age <= '0;
        else if (i_cfg_valid) r_max_age <= i_cfg_data;
    end

    sst_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_go(i_start), .i_stat(w_stat),
        .o_cmd(w_cmd), .o_busy, .o_strobe
    );

    sst_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_req_type,
        .i_name({i_name_word3, i_name_word2, i_name_word1, i_name_word0}),
        .i_signal_level, .i_radio_channel, .i_time_ms, .i_entry_index,
        .i_max_age_ms(r_max_age), .o_stat(w_stat), .o_status,
        .o_name(w_name), .o_level(o_out_level), .o_channel(o_out_channel),
        .o_total(o_entry_total), .o_ready(o_scan_ready), .o_stamp(o_scan_stamp)
    );

    assign o_out_word0 = w_name[63:0];
    assign o_out_word1 = w_name[127:64];
    assign o_out_word2 = w_name[191:128];
    assign o_out_word3 = w_name[255:192];
endmodule

// File: test/strongest_signal_table_core_tb.sv
// Self-checking testbench for the strongest signal table core: directed and random requests.
module strongest_signal_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sst_pkg::*;

    typedef struct packed {
        logic [2:0]   status;
        logic [255:0] name;
        logic [7:0]   level;
        logic [7:0]   channel;
        logic [4:0]   total;
        logic         ready;
        logic [31:0]  stamp;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    logic [2:0] i_req_type = '0;
    logic [63:0] i_name_word0 = '0, i_name_word1 = '0, i_name_word2 = '0, i_name_word3 = '0;
    logic signed [7:0] i_signal_level = '0;
    logic [7:0] i_radio_channel = '0;
    logic [31:0] i_time_ms = '0;
    logic [7:0] i_entry_index = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic o_strobe;
    logic [2:0] o_status;
    logic [63:0] o_out_word0, o_out_word1, o_out_word2, o_out_word3;
    logic signed [7:0] o_out_level;
    logic [7:0] o_out_channel;
    logic [4:0] o_entry_total;
    logic o_scan_ready;
    logic [31:0] o_scan_stamp;

    strongest_signal_table_core i_dut (.*);

    always #1 i_clk = ~i_clk;

    // Predicted table state.
    logic [255:0]      tbl_name [ENTRIES];
    logic signed [7:0] tbl_level [ENTRIES];
    logic [7:0]        tbl_chan [ENTRIES];
    int unsigned       tbl_count;
    logic [31:0]       tbl_stamp;
    logic              tbl_ready;
    logic [31:0]       age_limit;

    t_answer pending_answers[$];
    logic [255:0] known_names[$];
    int  fail_count = 0;
    longint cycle_count = 0;

    function automatic logic [255:0] trimmed(input logic [255:0] nm);
        logic [255:0] r;
        logic ended;
        r = '0;
        ended = 1'b0;
        for (int b = 0; b < 32; b++) begin
            if (b >= NAME_BYTES || nm[b*8 +: 8] == 8'd0) ended = 1'b1;
            if (!ended) r[b*8 +: 8] = nm[b*8 +: 8];
        end
        return r;
    endfunction

    function automatic void empty_table();
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_name[i] = '0;
            tbl_level[i] = '0;
            tbl_chan[i] = '0;
        end
        tbl_count = 0;
        tbl_ready = 1'b0;
    endfunction

    function automatic int find_slot(input logic [255:0] nm);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_name[i] == nm) return i;
        return -1;
    endfunction

    function automatic void add_signal(input logic [255:0] nm, input logic signed [7:0] lv,
                                       input logic [7:0] ch);
        int idx;
        if (nm[7:0] == 8'd0) return;
        idx = find_slot(nm);
        if (idx >= 0) begin
            if (lv > tbl_level[idx]) begin
                tbl_level[idx] = lv;
                tbl_chan[idx] = ch;
            end
            return;
        end
        if (tbl_count < ENTRIES) begin
            idx = tbl_count;
            tbl_count++;
        end else begin
            idx = 0;
            for (int i = 1; i < ENTRIES; i++)
                if (tbl_level[i] < tbl_level[idx]) idx = i;
            if (lv <= tbl_level[idx]) return;
        end
        tbl_name[idx] = nm;
        tbl_level[idx] = lv;
        tbl_chan[idx] = ch;
    endfunction

    function automatic void sort_by_level();
        logic [255:0] kn;
        logic signed [7:0] kl;
        logic [7:0] kc;
        int j;
        for (int i = 1; i < tbl_count; i++) begin
            kn = tbl_name[i];
            kl = tbl_level[i];
            kc = tbl_chan[i];
            j = i;
            while (j > 0 && kl > tbl_level[j-1]) begin
                tbl_name[j] = tbl_name[j-1];
                tbl_level[j] = tbl_level[j-1];
                tbl_chan[j] = tbl_chan[j-1];
                j--;
            end
            tbl_name[j] = kn;
            tbl_level[j] = kl;
            tbl_chan[j] = kc;
        end
    endfunction

    function automatic t_answer answer_request(input logic [2:0] req, input logic [255:0] raw,
                                               input logic signed [7:0] lv, input logic [7:0] ch,
                                               input logic [31:0] now, input logic [7:0] ix);
        t_answer a;
        logic [255:0] nm;
        int hit;
        nm = trimmed(raw);
        hit = -1;
        a = '0;
        a.status = ST_DONE;
        case (req)
            REQ_CLEAR: begin
                empty_table();
                tbl_stamp = '0;
            end
            REQ_BEGIN: empty_table();
            REQ_ADD: add_signal(nm, lv, ch);
            REQ_FINISH: begin
                sort_by_level();
                tbl_stamp = now;
                tbl_ready = 1'b1;
            end
            REQ_LOOKUP: begin
                if (nm[7:0] == 8'd0 || !tbl_ready) a.status = ST_NOT_AVAIL;
                else if (age_limit != 0 && (now - tbl_stamp) > age_limit) a.status = ST_STALE;
                else begin
                    hit = find_slot(nm);
                    a.status = hit < 0 ? ST_NOT_FOUND : ST_FOUND;
                end
            end
            REQ_READ: begin
                if (ix >= tbl_count) a.status = ST_RANGE;
                else begin
                    hit = ix;
                    a.status = ST_FOUND;
                end
            end
            default: ;
        endcase
        if (hit >= 0) begin
            a.name = tbl_name[hit];
            a.level = tbl_level[hit];
            a.channel = tbl_chan[hit];
        end
        a.total = tbl_count[4:0];
        a.ready = tbl_ready;
        a.stamp = tbl_stamp;
        return a;
    endfunction

    // Start stays high after a transfer until the next request or a drain; the core is
    // busy then, so nothing is taken twice.
    task automatic send_request(input logic [2:0] req, input logic [255:0] raw,
                                input logic signed [7:0] lv, input logic [7:0] ch,
                                input logic [31:0] now, input logic [7:0] ix);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req_type <= req;
        {i_name_word3, i_name_word2, i_name_word1, i_name_word0} <= raw;
        i_signal_level <= lv;
        i_radio_channel <= ch;
        i_time_ms <= now;
        i_entry_index <= ix;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_answers.push_back(answer_request(req, raw, lv, ch, now, ix));
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_age_limit(input logic [31:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        age_limit = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly names from a small pool of random names, so that repeats and hits happen.
    function automatic logic [255:0] pick_name();
        logic [255:0] n;
        int len;
        if (known_names.size() != 0 && $urandom_range(0, 2) != 0)
            return known_names[$urandom_range(0, known_names.size() - 1)];
        n = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 4) != 0) begin
            len = $urandom_range(1, 32);
            for (int b = 0; b < 32; b++)
                if (b >= len) n[b*8 +: 8] = 8'd0;
        end
        if ($urandom_range(0, 30) == 0) n[7:0] = 8'd0;
        if (known_names.size() < 24) known_names.push_back(n);
        return n;
    endfunction

    task automatic test_directed();
        logic [255:0] full_name;
        full_name = '1;
        send_request(REQ_LOOKUP, full_name, 0, 0, 0, 0);
        send_request(REQ_READ, '0, 0, 0, 0, 0);
        send_request(REQ_BEGIN, '0, 0, 0, 0, 0);
        send_request(REQ_ADD, full_name, 8'sd127, 8'hFF, 0, 0);
        send_request(REQ_ADD, '0, 8'sd5, 8'h01, 0, 0);
        send_request(REQ_ADD, {248'd0, 8'h41}, -8'sd128, 8'h00, 0, 0);
        send_request(REQ_ADD, {248'd0, 8'h41}, -8'sd128, 8'h07, 0, 0);
        send_request(REQ_ADD, {192'd0, 64'h0000_0042_0000_0041}, 8'sd3, 8'h02, 0, 0);
        send_request(REQ_ADD, {248'd0, 8'h41}, 8'sd10, 8'h09, 0, 0);
        send_request(REQ_LOOKUP, {248'd0, 8'h41}, 0, 0, 0, 0);
        send_request(REQ_FINISH, '0, 0, 0, 32'hFFFF_FFF0, 0);
        send_request(REQ_LOOKUP, {248'd0, 8'h41}, 0, 0, 32'h0000_0010, 0);
        send_request(REQ_LOOKUP, {248'd0, 8'h43}, 0, 0, 0, 0);
        send_request(REQ_LOOKUP, '0, 0, 0, 0, 0);
        send_request(REQ_READ, '0, 0, 0, 0, 8'd0);
        send_request(REQ_READ, '0, 0, 0, 0, 8'd2);
        send_request(REQ_READ, '0, 0, 0, 0, 8'd3);
        send_request(REQ_READ, '0, 0, 0, 0, 8'd255);
        send_request(3'd6, full_name, 0, 0, 32'h1234, 0);
        send_request(3'd7, full_name, 0, 0, 32'h1234, 0);
        send_request(REQ_CLEAR, '0, 0, 0, 0, 0);
        send_request(REQ_LOOKUP, {248'd0, 8'h41}, 0, 0, 0, 0);
    endtask

    // Stale checks around the limit, then the widest limit.
    task automatic test_age_limit();
        write_age_limit(32'd100);
        send_request(REQ_BEGIN, '0, 0, 0, 0, 0);
        send_request(REQ_ADD, {248'd0, 8'h5A}, 8'sd1, 8'd6, 0, 0);
        send_request(REQ_FINISH, '0, 0, 0, 32'd1000, 0);
        send_request(REQ_LOOKUP, {248'd0, 8'h5A}, 0, 0, 32'd1100, 0);
        send_request(REQ_LOOKUP, {248'd0, 8'h5A}, 0, 0, 32'd1101, 0);
        send_request(REQ_LOOKUP, {248'd0, 8'h5A}, 0, 0, 32'd999, 0);
        write_age_limit(32'hFFFF_FFFF);
        send_request(REQ_LOOKUP, {248'd0, 8'h5A}, 0, 0, 32'd999, 0);
        write_age_limit(32'd0);
    endtask

    // Scans of random length, often overfilling the table, then lookups and reads.
    task automatic test_random_scans();
        int items;
        int adds;
        logic [31:0] now;
        logic [2:0] r;
        items = 0;
        now = $urandom;
        while (items < 800) begin
            if ($urandom_range(0, 9) == 0) begin
                r = 3'($urandom_range(0, 7));
                send_request(r, pick_name(), 8'($urandom), 8'($urandom), $urandom,
                             8'($urandom));
                items++;
                continue;
            end
            if (items > 400 && items < 420) write_age_limit($urandom_range(1, 3000));
            if (items > 600 && items < 620) write_age_limit(32'd0);
            known_names.delete();
            send_request(REQ_BEGIN, pick_name(), 0, 0, 0, 0);
            adds = ($urandom_range(0, 2) == 0) ? $urandom_range(17, 30) : $urandom_range(0, 16);
            for (int k = 0; k < adds; k++)
                send_request(REQ_ADD, pick_name(), 8'($urandom), 8'($urandom), 0, 0);
            now += $urandom_range(0, 5000);
            send_request(REQ_FINISH, '0, 0, 0, now, 0);
            items += adds + 2;
            repeat ($urandom_range(2, 8)) begin
                now += $urandom_range(0, 1500);
                if ($urandom_range(0, 1) == 0)
                    send_request(REQ_LOOKUP, pick_name(), 0, 0, now, 0);
                else
                    send_request(REQ_READ, '0, 0, 0, 0, 8'($urandom_range(0, 18)));
                items++;
            end
            if ($urandom_range(0, 5) == 0) begin
                send_request(REQ_ADD, pick_name(), 8'($urandom), 8'($urandom), 0, 0);
                send_request(REQ_READ, '0, 0, 0, 0, 8'($urandom_range(0, 255)));
                items += 2;
            end
        end
    endtask

    // Every result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_strobe) begin
            if (pending_answers.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                e = pending_answers.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); fail_count++;
                end
                if (o_out_word0 !== e.name[63:0]) begin
                    $error("out_word0 exp %h got %h", e.name[63:0], o_out_word0); fail_count++;
                end
                if (o_out_word1 !== e.name[127:64]) begin
                    $error("out_word1 exp %h got %h", e.name[127:64], o_out_word1); fail_count++;
                end
                if (o_out_word2 !== e.name[191:128]) begin
                    $error("out_word2 exp %h got %h", e.name[191:128], o_out_word2); fail_count++;
                end
                if (o_out_word3 !== e.name[255:192]) begin
                    $error("out_word3 exp %h got %h", e.name[255:192], o_out_word3); fail_count++;
                end
                if (o_out_level !== e.level) begin
                    $error("out_level exp %0d got %0d", $signed(e.level), o_out_level);
                    fail_count++;
                end
                if (o_out_channel !== e.channel) begin
                    $error("out_channel exp %0d got %0d", e.channel, o_out_channel); fail_count++;
                end
                if (o_entry_total !== e.total) begin
                    $error("entry_total exp %0d got %0d", e.total, o_entry_total); fail_count++;
                end
                if (o_scan_ready !== e.ready) begin
                    $error("scan_ready exp %0d got %0d", e.ready, o_scan_ready); fail_count++;
                end
                if (o_scan_stamp !== e.stamp) begin
                    $error("scan_stamp exp %0d got %0d", e.stamp, o_scan_stamp); fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 2000000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        empty_table();
        tbl_stamp = '0;
        age_limit = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_age_limit();
        test_random_scans();
        drain();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
